[rtl/core/ddma_pkg.sv]
// shared types and constants for the dual dma controller
`default_nettype none

package ddma_pkg;

    // opcodes of one request
    localparam logic [1:0] OP_PORT_WR = 2'd0;
    localparam logic [1:0] OP_PORT_RD = 2'd1;
    localparam logic [1:0] OP_XFER_RD = 2'd2;
    localparam logic [1:0] OP_XFER_WR = 2'd3;

    // control port functions, offset from the status/command port
    localparam logic [2:0] FN_STATUS   = 3'd0;
    localparam logic [2:0] FN_REQUEST  = 3'd1;
    localparam logic [2:0] FN_MASK_ONE = 3'd2;
    localparam logic [2:0] FN_MODE     = 3'd3;
    localparam logic [2:0] FN_CLR_PTR  = 3'd4;
    localparam logic [2:0] FN_MCLR     = 3'd5;
    localparam logic [2:0] FN_CLR_MASK = 3'd6;
    localparam logic [2:0] FN_ALL_MASK = 3'd7;

    localparam logic [7:0] UNMAPPED_READ = 8'hFF;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] port_address;
        logic [7:0] data_byte;
        logic [2:0] channel;
    } t_in;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [23:0] mem_address;
        logic        mem_write;
        logic [7:0]  mem_wdata;
        logic        terminal_reached;
        logic [7:0]  mask_bits;
    } t_out;

    // commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

`default_nettype wire

[rtl/core/ddma_datapath.sv]
// register file, port decode and transfer stepping of both controllers
`default_nettype none

module ddma_datapath
    import ddma_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cmd i_cmd,
    input  wire t_in  i_req,
    output t_out      o_res
);

    logic [15:0] r_cur_addr [8];
    logic [15:0] r_base_addr [8];
    logic [15:0] r_cur_cnt [8];
    logic [15:0] r_base_cnt [8];
    logic [7:0]  r_page [8];
    logic [7:0]  r_page_rb [16];
    logic [1:0]  r_bptr;
    logic [7:0]  r_auto;
    logic [7:0]  r_down;
    logic [7:0]  r_dreq;
    logic [7:0]  r_term;
    logic [7:0]  r_mask;
    t_in         r_req;
    t_out        r_res;

    logic [15:0] n_cur_addr [8];
    logic [15:0] n_base_addr [8];
    logic [15:0] n_cur_cnt [8];
    logic [15:0] n_base_cnt [8];
    logic [7:0]  n_page [8];
    logic [7:0]  n_page_rb [16];
    logic [1:0]  n_bptr;
    logic [7:0]  n_auto;
    logic [7:0]  n_down;
    logic [7:0]  n_dreq;
    logic [7:0]  n_term;
    logic [7:0]  n_mask;
    t_out        n_res;

    // port decode
    logic [7:0]  port;
    logic [7:0]  v;
    logic        is_reg;
    logic        reg_ctl;
    logic [2:0]  reg_ch;
    logic        is_cnt;
    logic        is_ctl;
    logic        ctl_ctl;
    logic [2:0]  fn;
    logic        is_page;
    logic        page_hit;
    logic [2:0]  page_ch;
    logic [2:0]  idx;
    logic        is_xfer;
    logic [15:0] reg_val;
    logic [15:0] reg_new;
    logic [15:0] addr_step;

    assign port = r_req.port_address;
    assign v    = r_req.data_byte;

    always_comb begin
        is_reg  = 1'b0;
        reg_ctl = 1'b0;
        reg_ch  = 3'd0;
        is_cnt  = 1'b0;
        if (port[7:3] == 5'b00000) begin
            is_reg = 1'b1;
            reg_ch = {1'b0, port[2:1]};
            is_cnt = port[0];
        end else if (port[7:4] == 4'hC && !port[0]) begin
            is_reg  = 1'b1;
            reg_ctl = 1'b1;
            reg_ch  = {1'b1, port[3:2]};
            is_cnt  = port[1];
        end
    end

    always_comb begin
        is_ctl  = 1'b0;
        ctl_ctl = 1'b0;
        fn      = FN_STATUS;
        if (port[7:3] == 5'b00001) begin
            is_ctl = 1'b1;
            fn     = port[2:0];
        end else if (port[7:4] == 4'hD && !port[0]) begin
            is_ctl  = 1'b1;
            ctl_ctl = 1'b1;
            fn      = port[3:1];
        end
    end

    // page ports and the channel each one loads
    assign is_page = (port[7:4] == 4'h8) && (port[3:0] != 4'h0);
    always_comb begin
        page_hit = 1'b1;
        case (port[3:0])
            4'h7:    page_ch = 3'd0;
            4'h3:    page_ch = 3'd1;
            4'h1:    page_ch = 3'd2;
            4'h2:    page_ch = 3'd3;
            4'hF:    page_ch = 3'd4;
            4'hB:    page_ch = 3'd5;
            4'h9:    page_ch = 3'd6;
            4'hA:    page_ch = 3'd7;
            default: begin
                page_hit = 1'b0;
                page_ch  = 3'd0;
            end
        endcase
    end

    // one channel index serves both transfers and register ports
    assign is_xfer   = r_req.opcode[1];
    assign idx       = is_xfer ? r_req.channel : reg_ch;
    assign reg_val   = is_cnt ? r_cur_cnt[idx] : r_cur_addr[idx];
    assign reg_new   = r_bptr[reg_ctl] ? {v, reg_val[7:0]} : {reg_val[15:8], v};
    assign addr_step = r_down[idx] ? r_cur_addr[idx] - 16'd1 : r_cur_addr[idx] + 16'd1;

    // next state and result of the request held in r_req
    always_comb begin
        n_cur_addr  = r_cur_addr;
        n_base_addr = r_base_addr;
        n_cur_cnt   = r_cur_cnt;
        n_base_cnt  = r_base_cnt;
        n_page      = r_page;
        n_page_rb   = r_page_rb;
        n_bptr      = r_bptr;
        n_auto      = r_auto;
        n_down      = r_down;
        n_dreq      = r_dreq;
        n_term      = r_term;
        n_mask      = r_mask;
        n_res       = '0;
        case (r_req.opcode)
            OP_PORT_WR: begin
                if (is_reg) begin
                    if (is_cnt) begin
                        n_cur_cnt[idx]  = reg_new;
                        n_base_cnt[idx] = reg_new;
                    end else begin
                        n_cur_addr[idx]  = reg_new;
                        n_base_addr[idx] = reg_new;
                    end
                    n_bptr[reg_ctl] = !r_bptr[reg_ctl];
                end else if (is_ctl) begin
                    case (fn)
                        FN_REQUEST:  n_dreq[{ctl_ctl, v[1:0]}] = v[2];
                        FN_MASK_ONE: n_mask[{ctl_ctl, v[1:0]}] = v[2];
                        FN_MODE: begin
                            n_auto[{ctl_ctl, v[1:0]}] = v[4];
                            n_down[{ctl_ctl, v[1:0]}] = v[5];
                        end
                        FN_CLR_PTR: n_bptr[ctl_ctl] = 1'b0;
                        FN_MCLR: begin
                            n_bptr[ctl_ctl] = 1'b0;
                            for (int i = 0; i < 4; i++) begin
                                n_mask[{ctl_ctl, 2'(i)}] = 1'b1;
                                n_dreq[{ctl_ctl, 2'(i)}] = 1'b0;
                                n_term[{ctl_ctl, 2'(i)}] = 1'b0;
                            end
                        end
                        FN_CLR_MASK: begin
                            for (int i = 0; i < 4; i++) begin
                                n_mask[{ctl_ctl, 2'(i)}] = 1'b0;
                            end
                        end
                        FN_ALL_MASK: begin
                            for (int i = 0; i < 4; i++) begin
                                n_mask[{ctl_ctl, 2'(i)}] = v[i];
                            end
                        end
                        default: ;
                    endcase
                end else if (is_page) begin
                    n_page_rb[port[3:0]] = v;
                    if (page_hit) begin
                        n_page[page_ch] = v;
                    end
                end
            end
            OP_PORT_RD: begin
                if (is_reg) begin
                    n_res.read_data = r_bptr[reg_ctl] ? reg_val[15:8] : reg_val[7:0];
                    n_bptr[reg_ctl] = !r_bptr[reg_ctl];
                end else if (is_ctl && fn == FN_STATUS) begin
                    for (int i = 0; i < 4; i++) begin
                        n_res.read_data[i]     = r_term[{ctl_ctl, 2'(i)}];
                        n_res.read_data[i + 4] = r_dreq[{ctl_ctl, 2'(i)}];
                        n_term[{ctl_ctl, 2'(i)}] = 1'b0;
                    end
                end else if (is_page) begin
                    n_res.read_data = r_page_rb[port[3:0]];
                end else begin
                    n_res.read_data = UNMAPPED_READ;
                end
            end
            default: begin
                // one transfer: emit address, step address, count down, and at count zero reload or flag terminal
                n_res.mem_address = {r_page[idx], r_cur_addr[idx]};
                if (r_req.opcode == OP_XFER_WR) begin
                    n_res.mem_write = 1'b1;
                    n_res.mem_wdata = v;
                end
                n_cur_addr[idx] = addr_step;
                n_cur_cnt[idx]  = r_cur_cnt[idx] - 16'd1;
                if (r_cur_cnt[idx] == 16'd0) begin
                    if (r_auto[idx]) begin
                        n_cur_cnt[idx]  = r_base_cnt[idx];
                        n_cur_addr[idx] = r_base_addr[idx];
                        n_term[idx]     = 1'b0;
                    end else begin
                        n_term[idx] = 1'b1;
                    end
                end
                n_res.terminal_reached = n_term[idx];
            end
        endcase
        n_res.mask_bits = n_mask;
    end

    // request and result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_req;
        end
        if (i_cmd.exec) begin
            r_res <= n_res;
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_cur_addr[i]  <= '0;
                r_base_addr[i] <= '0;
                r_cur_cnt[i]   <= '0;
                r_base_cnt[i]  <= '0;
                r_page[i]      <= '0;
            end
            for (int i = 0; i < 16; i++) begin
                r_page_rb[i] <= '0;
            end
            r_bptr <= '0;
            r_auto <= '0;
            r_down <= '0;
            r_dreq <= '0;
            r_term <= '0;
            r_mask <= '1;
        end else if (i_cmd.exec) begin
            r_cur_addr  <= n_cur_addr;
            r_base_addr <= n_base_addr;
            r_cur_cnt   <= n_cur_cnt;
            r_base_cnt  <= n_base_cnt;
            r_page      <= n_page;
            r_page_rb   <= n_page_rb;
            r_bptr      <= n_bptr;
            r_auto      <= n_auto;
            r_down      <= n_down;
            r_dreq      <= n_dreq;
            r_term      <= n_term;
            r_mask      <= n_mask;
        end
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

[rtl/core/ddma_ctrl.sv]
// request sequencer: accept, execute, hold result
`default_nettype none

module ddma_ctrl
    import ddma_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_EXEC;
            S_EXEC:  n_state = S_DONE;
            S_DONE:  if (!i_out_stall) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // handshake and datapath commands
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = (r_state == S_DONE);
    assign o_cmd.load  = i_in_valid && (r_state == S_IDLE);
    assign o_cmd.exec  = (r_state == S_EXEC);

    a_load_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> o_cmd.exec)
        else $error("accepted request not executed");
    a_exec_then_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_out_valid)
        else $error("executed request gave no result");
    a_no_accept_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_in_stall)
        else $error("request accepted while result pending");
    a_no_load_during_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> !o_cmd.load)
        else $error("load during execute");

endmodule

`default_nettype wire

[rtl/core/dual_dma_controller_8237_top.sv]
// top level of the dual dma controller with page registers
// an accepted request is latched in the request register, executed into the result register, then shown as valid
// the accept/execute/output sequencer takes a new request only once the last one is through
// a stalled result holds the next request off until it is taken
// reset (synchronous, active low) clears all channel registers and sets all channel masks
`default_nettype none

module dual_dma_controller_8237_top
    import ddma_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_stall,
    input  wire t_in  i_in_data,
    output logic      o_out_valid,
    input  wire logic i_out_stall,
    output t_out      o_out_data
);

    t_cmd cmd;

    // sequencer
    ddma_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // register file and transfer logic
    ddma_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_in_data),
        .o_res   (o_out_data)
    );

endmodule

`default_nettype wire

[sim/tb_dual_dma_controller_8237_top.sv]
`timescale 1ns / 100ps
// self-checking testbench for the dual dma controller top level

module tb_dual_dma_controller_8237_top;
    import ddma_pkg::*;

    localparam int STALL_LIMIT  = 4000;
    localparam int PHASE_ITEMS  = 134;
    localparam int DRAIN_CYCLES = 8;
    localparam int PRINT_LIMIT  = 100;

    // unmapped ports: gap below the page block, odd port of the second controller
    localparam logic [7:0] PORT_GAP     = 8'h80;
    localparam logic [7:0] PORT_ODD_SEC = 8'hC1;

    typedef struct {
        t_in  req;
        bit   typed;
        t_out want;
    } plan_row_t;

    logic i_clk;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic out_stall = 1'b0;
    logic in_stall;
    logic out_valid;
    t_out out_data;

    // shadow of the controller pair
    bit [15:0] cur_addr [8];
    bit [15:0] base_addr [8];
    bit [15:0] cur_cnt [8];
    bit [15:0] base_cnt [8];
    bit [7:0]  chan_page [8];
    bit [7:0]  page_shadow [16];
    bit        byte_ptr [2];
    bit        autoinit [8];
    bit        addr_down [8];
    bit        req_bit [8];
    bit        tc_flag [8];
    bit [7:0]  chan_mask = 8'hFF;

    t_out expect_q [$];
    int   err_count     = 0;
    int   n_items       = 0;
    int   n_results     = 0;
    int   n_xfers       = 0;
    int   n_terminal    = 0;
    int   n_reads       = 0;
    int   send_idle_pct = 0;
    int   recv_idle_pct = 0;
    int   idle_cycles   = 0;

    dual_dma_controller_8237_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // page register port of each channel
    function automatic logic [7:0] page_port(input int ch);
        case (ch)
            0: return 8'h87;
            1: return 8'h83;
            2: return 8'h81;
            3: return 8'h82;
            4: return 8'h8F;
            5: return 8'h8B;
            6: return 8'h89;
            default: return 8'h8A;
        endcase
    endfunction

    // address or count port of a channel
    function automatic logic [7:0] reg_port(input int ch, input bit cnt);
        if (ch < 4) return {5'b00000, 2'(ch), cnt};
        return {4'hC, 2'(ch - 4), cnt, 1'b0};
    endfunction

    // control port of a controller
    function automatic logic [7:0] ctl_port(input bit ctl, input logic [2:0] fn);
        return ctl ? {4'hD, fn, 1'b0} : {5'b00001, fn};
    endfunction

    function automatic t_in req_of(input logic [1:0] op, input logic [7:0] port,
                                   input logic [7:0] data, input int ch);
        t_in r;
        r.opcode       = op;
        r.port_address = port;
        r.data_byte    = data;
        r.channel      = 3'(ch);
        return r;
    endfunction

    // result of a port access: only read data and masks
    function automatic t_out port_res(input logic [7:0] rd, input logic [7:0] mask);
        t_out r;
        r           = '0;
        r.read_data = rd;
        r.mask_bits = mask;
        return r;
    endfunction

    // next result of the controller pair, updating the shadow state
    function automatic t_out predict_result(input t_in req);
        t_out        res;
        logic [7:0]  p;
        logic [7:0]  d;
        logic [15:0] val;
        logic [2:0]  fn;
        bit          is_reg;
        bit          is_ctl;
        bit          is_page;
        bit          cnt_sel;
        bit          ctl;
        int          ch;
        int          sel;
        int          first;
        int          i;
        res     = '0;
        p       = req.port_address;
        d       = req.data_byte;
        is_reg  = (p <= 8'h07) || (p >= 8'hC0 && p <= 8'hCE && !p[0]);
        is_ctl  = (p >= 8'h08 && p <= 8'h0F) || (p >= 8'hD0 && p <= 8'hDE && !p[0]);
        is_page = (p >= 8'h81 && p <= 8'h8F);
        ctl     = p[7];
        ch      = ctl ? 4 + int'(p[3:2]) : int'(p[2:1]);
        cnt_sel = ctl ? p[1] : p[0];
        fn      = ctl ? p[3:1] : p[2:0];
        first   = ctl ? 4 : 0;
        sel     = first + int'(d[1:0]);
        val     = cnt_sel ? cur_cnt[ch] : cur_addr[ch];
        case (req.opcode)
            OP_PORT_WR: begin
                if (is_reg) begin
                    // byte load also sets the reload copy
                    if (byte_ptr[ctl]) val[15:8] = d;
                    else val[7:0] = d;
                    if (cnt_sel) begin
                        cur_cnt[ch]  = val;
                        base_cnt[ch] = val;
                    end else begin
                        cur_addr[ch]  = val;
                        base_addr[ch] = val;
                    end
                    byte_ptr[ctl] = !byte_ptr[ctl];
                end else if (is_ctl) begin
                    case (fn)
                        FN_REQUEST:  req_bit[sel] = d[2];
                        FN_MASK_ONE: chan_mask[sel] = d[2];
                        FN_MODE: begin
                            autoinit[sel]  = d[4];
                            addr_down[sel] = d[5];
                        end
                        FN_CLR_PTR:  byte_ptr[ctl] = 1'b0;
                        FN_MCLR: begin
                            byte_ptr[ctl] = 1'b0;
                            for (i = first; i < first + 4; i++) begin
                                chan_mask[i] = 1'b1;
                                req_bit[i]   = 1'b0;
                                tc_flag[i]   = 1'b0;
                            end
                        end
                        FN_CLR_MASK: for (i = first; i < first + 4; i++) chan_mask[i] = 1'b0;
                        FN_ALL_MASK: for (i = 0; i < 4; i++) chan_mask[first + i] = d[i];
                        default: ;  // command write does nothing
                    endcase
                end else if (is_page) begin
                    page_shadow[p[3:0]] = d;
                    for (i = 0; i < 8; i++)
                        if (page_port(i) == p) chan_page[i] = d;
                end
            end
            OP_PORT_RD: begin
                if (is_reg) begin
                    res.read_data = byte_ptr[ctl] ? val[15:8] : val[7:0];
                    byte_ptr[ctl] = !byte_ptr[ctl];
                end else if (is_ctl && fn == FN_STATUS) begin
                    // status read clears the terminal flags
                    for (i = 0; i < 4; i++) begin
                        res.read_data[i]     = tc_flag[first + i];
                        res.read_data[i + 4] = req_bit[first + i];
                        tc_flag[first + i]   = 1'b0;
                    end
                end else if (is_page) begin
                    res.read_data = page_shadow[p[3:0]];
                end else begin
                    res.read_data = UNMAPPED_READ;
                end
            end
            default: begin
                ch = int'(req.channel);
                res.mem_address = {chan_page[ch], cur_addr[ch]};
                if (req.opcode == OP_XFER_WR) begin
                    res.mem_write = 1'b1;
                    res.mem_wdata = d;
                end
                cur_addr[ch] = addr_down[ch] ? cur_addr[ch] - 16'd1 : cur_addr[ch] + 16'd1;
                cur_cnt[ch]  = cur_cnt[ch] - 16'd1;
                // count wrapped past zero: reload or flag terminal
                if (cur_cnt[ch] == 16'hFFFF) begin
                    if (autoinit[ch]) begin
                        cur_cnt[ch]  = base_cnt[ch];
                        cur_addr[ch] = base_addr[ch];
                        tc_flag[ch]  = 1'b0;
                    end else begin
                        tc_flag[ch] = 1'b1;
                    end
                end
                res.terminal_reached = tc_flag[ch];
            end
        endcase
        res.mask_bits = chan_mask;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [23:0] got,
                                   input logic [23:0] want);
        if (err_count < PRINT_LIMIT)
            $display("mismatch at result %0d: %s got 0x%0h want 0x%0h",
                     n_results, what, got, want);
        err_count++;
    endtask

    // present one request, wait for it to be taken, queue its result
    task automatic send_request(input t_in req, input bit typed, input t_out want);
        t_out pred;
        if (send_idle_pct != 0 && int'($urandom_range(99)) < send_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        do @(posedge i_clk); while (in_stall !== 1'b0);
        pred = predict_result(req);
        expect_q.push_back(typed ? want : pred);
        n_items++;
        if (req.opcode == OP_PORT_RD) n_reads++;
        if (req.opcode[1]) n_xfers++;
        if (pred.terminal_reached) n_terminal++;
    endtask

    // receiver stall
    always @(posedge i_clk) begin
        out_stall <= (recv_idle_pct != 0) && (int'($urandom_range(99)) < recv_idle_pct);
    end

    // result checking
    always @(posedge i_clk) begin : result_check
        t_out want;
        if (i_rst_n && out_valid === 1'b1 && !out_stall) begin
            n_results++;
            if (expect_q.size() == 0) begin
                report_mismatch("result with no request outstanding", out_data.mem_address, 0);
            end else begin
                want = expect_q.pop_front();
                if (out_data.read_data !== want.read_data)
                    report_mismatch("read_data", out_data.read_data, want.read_data);
                if (out_data.mem_address !== want.mem_address)
                    report_mismatch("mem_address", out_data.mem_address, want.mem_address);
                if (out_data.mem_write !== want.mem_write)
                    report_mismatch("mem_write", out_data.mem_write, want.mem_write);
                if (out_data.mem_wdata !== want.mem_wdata)
                    report_mismatch("mem_wdata", out_data.mem_wdata, want.mem_wdata);
                if (out_data.terminal_reached !== want.terminal_reached)
                    report_mismatch("terminal_reached", out_data.terminal_reached,
                                    want.terminal_reached);
                if (out_data.mask_bits !== want.mask_bits)
                    report_mismatch("mask_bits", out_data.mask_bits, want.mask_bits);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout after %0d cycles without a handshake", idle_cycles);
            $display("dual_dma_controller_8237_top verification failed");
            $finish;
        end
    end

    // stimulus
    initial begin
        plan_row_t   plan [$];
        t_in         r;
        logic [15:0] v16;
        bit          ctl;
        int          n_dir;
        int          phase;
        int          pick;
        int          ch;
        int          n;
        int          nx;
        int          j;
        int          k;

        // directed requests: reset values, extremes, every port function but the pointer clear
        plan.push_back('{req_of(OP_PORT_RD, ctl_port(1'b0, FN_STATUS), 8'h00, 0), 1'b1,
                         port_res(8'h00, 8'hFF)});
        plan.push_back('{req_of(OP_PORT_RD, PORT_GAP, 8'hFF, 7), 1'b1,
                         port_res(UNMAPPED_READ, 8'hFF)});
        plan.push_back('{req_of(OP_PORT_RD, PORT_ODD_SEC, 8'h00, 0), 1'b1,
                         port_res(UNMAPPED_READ, 8'hFF)});
        plan.push_back('{req_of(OP_PORT_RD, ctl_port(1'b0, FN_MASK_ONE), 8'h00, 0), 1'b1,
                         port_res(UNMAPPED_READ, 8'hFF)});
        plan.push_back('{req_of(OP_PORT_WR, reg_port(0, 1'b0), 8'hFF, 0), 1'b1,
                         port_res(8'h00, 8'hFF)});
        plan.push_back('{req_of(OP_PORT_WR, reg_port(0, 1'b0), 8'hFF, 0), 1'b1,
                         port_res(8'h00, 8'hFF)});
        plan.push_back('{req_of(OP_PORT_WR, reg_port(0, 1'b1), 8'h00, 0), 1'b1,
                         port_res(8'h00, 8'hFF)});
        plan.push_back('{req_of(OP_PORT_WR, reg_port(0, 1'b1), 8'h00, 0), 1'b1,
                         port_res(8'h00, 8'hFF)});
        plan.push_back('{req_of(OP_PORT_WR, page_port(0), 8'hFF, 0), 1'b1,
                         port_res(8'h00, 8'hFF)});
        // count zero wraps at once: terminal on the first transfer, address wraps
        plan.push_back('{req_of(OP_XFER_WR, 8'h00, 8'hA5, 0), 1'b1,
                         t_out'{8'h00, 24'hFFFFFF, 1'b1, 8'hA5, 1'b1, 8'hFF}});
        plan.push_back('{req_of(OP_PORT_RD, ctl_port(1'b0, FN_STATUS), 8'h00, 0), 1'b1,
                         port_res(8'h01, 8'hFF)});
        plan.push_back('{req_of(OP_XFER_RD, 8'hFF, 8'hFF, 0), 1'b1,
                         t_out'{8'h00, 24'hFF0000, 1'b0, 8'h00, 1'b0, 8'hFF}});
        plan.push_back('{req_of(OP_PORT_WR, ctl_port(1'b0, FN_MODE), 8'h30, 0), 1'b1,
                         port_res(8'h00, 8'hFF)});
        plan.push_back('{req_of(OP_PORT_WR, ctl_port(1'b0, FN_CLR_MASK), 8'h00, 0), 1'b1,
                         port_res(8'h00, 8'hF0)});
        plan.push_back('{req_of(OP_PORT_WR, ctl_port(1'b1, FN_ALL_MASK), 8'h0A, 0), 1'b1,
                         port_res(8'h00, 8'hA0)});
        plan.push_back('{req_of(OP_PORT_WR, ctl_port(1'b1, FN_REQUEST), 8'h05, 0), 1'b0, '0});
        plan.push_back('{req_of(OP_PORT_WR, ctl_port(1'b1, FN_MASK_ONE), 8'h04, 0), 1'b0, '0});
        plan.push_back('{req_of(OP_PORT_WR, reg_port(5, 1'b0), 8'h12, 0), 1'b0, '0});
        plan.push_back('{req_of(OP_PORT_WR, reg_port(5, 1'b0), 8'h34, 0), 1'b0, '0});
        plan.push_back('{req_of(OP_PORT_RD, reg_port(5, 1'b0), 8'h00, 0), 1'b0, '0});
        plan.push_back('{req_of(OP_PORT_RD, reg_port(5, 1'b0), 8'h00, 0), 1'b0, '0});
        plan.push_back('{req_of(OP_PORT_RD, ctl_port(1'b1, FN_STATUS), 8'h00, 0), 1'b0, '0});
        plan.push_back('{req_of(OP_PORT_WR, ctl_port(1'b1, FN_MCLR), 8'h00, 0), 1'b0, '0});
        // transfer on a masked channel still runs
        plan.push_back('{req_of(OP_XFER_WR, 8'h00, 8'h00, 7), 1'b0, '0});
        plan.push_back('{req_of(OP_PORT_RD, page_port(4), 8'h00, 0), 1'b0, '0});
        plan.push_back('{req_of(OP_PORT_WR, ctl_port(1'b0, FN_STATUS), 8'hFF, 0), 1'b0, '0});
        n_dir = plan.size();

        // reset
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 20;
        recv_idle_pct = 75;
        foreach (plan[idx]) send_request(plan[idx].req, plan[idx].typed, plan[idx].want);

        // random part, three idle mixes
        for (phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 20;
                    recv_idle_pct = 75;
                end
                1: begin
                    send_idle_pct = 75;
                    recv_idle_pct = 20;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            while (n_items < n_dir + (phase + 1) * PHASE_ITEMS) begin
                pick = int'($urandom_range(9));
                r    = 21'($urandom);
                if (pick < 5) begin
                    // program one channel, then run transfers on it, past its terminal count when the count is short
                    ch  = int'($urandom_range(7));
                    ctl = (ch >= 4);
                    r.opcode       = OP_PORT_WR;
                    r.port_address = ctl_port(ctl, FN_CLR_PTR);
                    send_request(r, 1'b0, '0);
                    n = ($urandom_range(7) == 0) ? int'($urandom_range(65535))
                                                 : int'($urandom_range(4));
                    for (j = 0; j < 2; j++) begin
                        case ($urandom_range(3))
                            0: v16 = 16'hFFFF;
                            1: v16 = 16'h0000;
                            default: v16 = 16'($urandom_range(65535));
                        endcase
                        if (j == 1) v16 = 16'(n);
                        for (k = 0; k < 2; k++) begin
                            r.port_address = reg_port(ch, j == 1);
                            r.data_byte    = (k == 1) ? v16[15:8] : v16[7:0];
                            send_request(r, 1'b0, '0);
                        end
                    end
                    r.port_address   = ctl_port(ctl, FN_MODE);
                    r.data_byte      = 8'($urandom_range(255));
                    r.data_byte[1:0] = 2'(ch);
                    send_request(r, 1'b0, '0);
                    r.port_address = page_port(ch);
                    r.data_byte    = 8'($urandom_range(255));
                    send_request(r, 1'b0, '0);
                    r.port_address   = ctl_port(ctl, FN_MASK_ONE);
                    r.data_byte      = 8'($urandom_range(255));
                    r.data_byte[1:0] = 2'(ch);
                    send_request(r, 1'b0, '0);
                    // enough transfers to pass the count when it is short
                    nx = (n > 4) ? int'($urandom_range(3, 1)) : n + int'($urandom_range(3, 1));
                    for (k = 0; k < nx; k++) begin
                        r.opcode       = $urandom_range(1) ? OP_XFER_WR : OP_XFER_RD;
                        r.channel      = 3'(ch);
                        r.data_byte    = 8'($urandom_range(255));
                        r.port_address = 8'($urandom_range(255));
                        send_request(r, 1'b0, '0);
                    end
                    r.opcode       = OP_PORT_RD;
                    r.port_address = ctl_port(ctl, FN_STATUS);
                    send_request(r, 1'b0, '0);
                    // address or count readback
                    if ($urandom_range(1)) begin
                        r.port_address = reg_port(ch, 1'($urandom_range(1)));
                        send_request(r, 1'b0, '0);
                        send_request(r, 1'b0, '0);
                    end
                end else if (pick < 7) begin
                    // port traffic around the mapped blocks
                    r.opcode = $urandom_range(1) ? OP_PORT_RD : OP_PORT_WR;
                    case ($urandom_range(3))
                        0: r.port_address = {4'h0, 4'($urandom_range(15))};
                        1: r.port_address = {4'h8, 4'($urandom_range(15))};
                        2: r.port_address = {3'b110, 5'($urandom_range(31))};
                        default: ;
                    endcase
                    send_request(r, 1'b0, '0);
                end else if (pick < 9) begin
                    // transfer on any channel
                    r.opcode[1] = 1'b1;
                    send_request(r, 1'b0, '0);
                end else begin
                    send_request(r, 1'b0, '0);
                end
            end
        end
        in_valid <= 1'b0;

        // drain
        while (expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d requests (%0d directed): %0d transfers, %0d port reads",
                 n_items, n_dir, n_xfers, n_reads);
        $display("%0d transfers left a terminal flag; idle mixes 20/75, 75/20 and none",
                 n_terminal);
        if (err_count == 0)
            $display("dual_dma_controller_8237_top verification clean");
        else
            $display("dual_dma_controller_8237_top verification failed");
        $finish;
    end

endmodule
